### src/rgb_led_wheel_controller_macros.svh
// Assertion macros shared by the RGB wheel controller RTL.
`ifndef RGB_LED_WHEEL_CONTROLLER_MACROS_SVH
`define RGB_LED_WHEEL_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define RLW_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RLW_ASSERT(lbl, prop, msg) \
  `RLW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define RLW_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define RLW_ASSERT(lbl, prop, msg)
`endif
`endif

### src/rlw_pkg.sv
// Types, constants and the key debounce step of the RGB wheel controller.
`timescale 1ns / 1ps
package rlw_pkg;

  localparam int unsigned DEB_W      = 24;
  localparam int unsigned LONG_W     = 32;
  localparam int unsigned WHEEL_W    = 24;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned BRIGHT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SPEED_W-1:0]  SPEED_MIN   = 8'd10;
  localparam logic [SPEED_W-1:0]  SPEED_MAX   = 8'd250;
  localparam logic [SPEED_W-1:0]  SPEED_RESET = 8'd50;
  localparam logic [BRIGHT_W-1:0] BRIGHT_TOP  = 8'd254;
  localparam logic [BRIGHT_W-1:0] BRIGHT_LOW  = 8'd2;
  localparam logic [BRIGHT_W-1:0] WHEEL_LOW   = 8'd1;
  localparam logic [7:0]          PRESS_SAT   = 8'd255;

  localparam logic [DEB_W-1:0]   DEB_RESET   = 24'd15000;
  localparam logic [LONG_W-1:0]  LONG_RESET  = 32'd3000000;
  localparam logic [WHEEL_W-1:0] RATE_RESET  = 24'd500000;
  localparam logic [WHEEL_W-1:0] WPER_RESET  = 24'd10000;
  localparam int unsigned        PWM_RST_INT = 15624;
  localparam logic [PWM_W-1:0]   PWM_RESET   = PWM_W'(PWM_RST_INT);
  localparam logic [PWM_W-1:0]   WIDTH_RESET = PWM_W'((2 * PWM_RST_INT) / 256);

  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_WHEEL    = 2'd2,
    CFG_PWM      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_BLUE  = 2'd2,
    MODE_GREEN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2
  } key_phase_e;

  typedef enum logic [2:0] {
    WP_R_UP = 3'd0,
    WP_G_DN = 3'd1,
    WP_B_UP = 3'd2,
    WP_R_DN = 3'd3,
    WP_G_UP = 3'd4,
    WP_B_DN = 3'd5
  } wheel_phase_e;

  typedef logic [2:0][BRIGHT_W-1:0] bright_t;
  typedef logic [2:0][PWM_W-1:0]    width_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    key_phase_e phase;
    logic       held;
    logic       press;
  } deb_res_t;

  // One sample of a three-state debounce machine; level is active low.
  function automatic deb_res_t deb_step(key_phase_e ph, logic held, logic level);
    deb_res_t r;
    r.phase = ph;
    r.held  = held;
    r.press = 1'b0;
    unique case (ph)
      PH_IDLE: begin
        if (!level) r.phase = PH_PRESS;
      end
      PH_PRESS: begin
        if (!level) begin
          r.phase = PH_RELEASE;
          r.held  = 1'b1;
          r.press = 1'b1;
        end else begin
          r.phase = PH_IDLE;
        end
      end
      PH_RELEASE: begin
        if (level) begin
          r.phase = PH_IDLE;
          r.held  = 1'b0;
        end
      end
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

### src/rlw_tick_if.sv
// Tick channel: valid/ready with the two raw key levels.
`timescale 1ns / 1ps
interface rlw_tick_if;
  logic valid;
  logic ready;
  logic key1_level;
  logic key2_level;

  modport source (output valid, output key1_level, output key2_level, input ready);
  modport sink (input valid, input key1_level, input key2_level, output ready);
endinterface

### src/rlw_res_if.sv
// Result channel: valid/ready with pulse widths, enables and status.
`timescale 1ns / 1ps
interface rlw_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_width;
  logic [15:0] green_width;
  logic [15:0] blue_width;
  logic        red_enable;
  logic        green_enable;
  logic        blue_enable;
  logic [1:0]  mode;
  logic        long_press_active;
  logic [7:0]  speed;

  modport source (
    output valid, output red_width, output green_width, output blue_width,
    output red_enable, output green_enable, output blue_enable, output mode,
    output long_press_active, output speed, input ready
  );
  modport sink (
    input valid, input red_width, input green_width, input blue_width,
    input red_enable, input green_enable, input blue_enable, input mode,
    input long_press_active, input speed, output ready
  );
endinterface

### src/rlw_div.sv
// Restoring divider, one quotient bit per cycle: wheel rate over speed.
`timescale 1ns / 1ps
module rlw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rlw_pkg::WHEEL_W-1:0]   dividend_i,
  input  logic [rlw_pkg::SPEED_W-1:0]   divisor_i,
  output logic [rlw_pkg::WHEEL_W-1:0]   quot_o,
  output rlw_pkg::unit_stat_t           stat_o
);

  localparam int unsigned CNT_W = $clog2(rlw_pkg::WHEEL_W);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [rlw_pkg::WHEEL_W-1:0]  dvd_q, dvd_d;
  logic [rlw_pkg::SPEED_W-1:0]  dvs_q, dvs_d;
  logic [rlw_pkg::SPEED_W-1:0]  rem_q, rem_d;
  logic [rlw_pkg::SPEED_W:0]    trial;
  logic                         fits;

  assign trial = {rem_q, dvd_q[rlw_pkg::WHEEL_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(rlw_pkg::WHEEL_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = (divisor_i == '0) ? rlw_pkg::SPEED_W'(1) : divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Quotient bits shift in where dividend bits leave.
      rem_d = fits ? rlw_pkg::SPEED_W'(trial - {1'b0, dvs_q})
                   : trial[rlw_pkg::SPEED_W-1:0];
      dvd_d = {dvd_q[rlw_pkg::WHEEL_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quot_o      = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### src/rlw_scale.sv
// Pulse width registers, scaled one color a cycle through one multiplier.
`timescale 1ns / 1ps
module rlw_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rlw_pkg::bright_t            bright_i,
  input  logic [rlw_pkg::PWM_W-1:0]   period_i,
  output rlw_pkg::width_t             widths_o,
  output rlw_pkg::unit_stat_t         stat_o
);

  logic                                         busy_q;
  logic                                         done_q;
  logic [1:0]                                   ch_q;
  rlw_pkg::width_t                              widths_q;
  logic [rlw_pkg::BRIGHT_W+rlw_pkg::PWM_W-1:0]  prod;

  assign prod = bright_i[ch_q] * period_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      ch_q     <= rlw_pkg::CH_R;
      widths_q <= {3{rlw_pkg::WIDTH_RESET}};
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ch_q   <= rlw_pkg::CH_R;
      end else if (busy_q) begin
        // Keep the upper bits: brightness times period over 256.
        widths_q[ch_q] <= prod[rlw_pkg::BRIGHT_W +: rlw_pkg::PWM_W];
        if (ch_q == rlw_pkg::CH_B) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ch_q <= ch_q + 1'b1;
        end
      end
    end
  end

  assign widths_o    = widths_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### src/rgb_led_wheel_controller.sv
// RGB LED color wheel controller: one tick per item, one status beat per tick.
// A tick with no wheel step is taken, finished and presented through the WAIT,
// KEY and OUT states; a tick that hits a wheel step also waits in WAIT for the
// restoring divider reloading the wheel period (rate over speed, one quotient
// bit a cycle) and, unless a long press is up, for the three pulse widths
// scaled through one shared multiplier. The tick channel is ready only between
// items; a finished beat waits in the output register while the next tick is
// taken. Configuration writes apply at once and belong between ticks.
`timescale 1ns / 1ps
`include "rgb_led_wheel_controller_macros.svh"
module rgb_led_wheel_controller #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rlw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rlw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  rlw_tick_if.sink                         tick_i,
  rlw_res_if.source                        res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_KEY  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [rlw_pkg::DEB_W-1:0]    deb_ticks_q;
  logic [rlw_pkg::LONG_W-1:0]   long_ticks_q;
  logic [rlw_pkg::WHEEL_W-1:0]  wheel_rate_q;
  logic [rlw_pkg::PWM_W-1:0]    pwm_period_q;

  rlw_pkg::key_phase_e          k1_phase_q, k1_phase_d, k2_phase_q, k2_phase_d;
  logic                         k1_held_q, k1_held_d, k2_held_q, k2_held_d;
  logic                         pending_q, pending_d;
  logic [rlw_pkg::DEB_W-1:0]    deb_count_q, deb_count_d;
  logic [TIMER_BITS-1:0]        long_count_q, long_count_d;
  logic                         long_run_q, long_run_d;
  logic                         long_flag_q, long_flag_d;
  logic [7:0]                   press_q, press_d;
  logic [rlw_pkg::WHEEL_W-1:0]  wheel_count_q, wheel_count_d;
  logic [rlw_pkg::WHEEL_W-1:0]  wheel_per_q, wheel_per_d;
  logic [rlw_pkg::SPEED_W-1:0]  speed_q, speed_d;
  rlw_pkg::bright_t             bright_q, bright_d;
  rlw_pkg::wheel_phase_e        wphase_q, wphase_d;
  rlw_pkg::mode_e               mode_q, mode_d;
  logic [2:0]                   enable_q, enable_d;
  logic                         k2_lvl_q, k2_lvl_d;
  logic                         start_div_q, start_div_d;
  logic                         start_scale_q, start_scale_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;

  logic [rlw_pkg::WHEEL_W-1:0]  quot;
  rlw_pkg::unit_stat_t          div_stat;
  rlw_pkg::unit_stat_t          scale_stat;
  rlw_pkg::width_t              widths;

  logic                         accept;

  assign tick_i.ready = (state_q == S_IDLE);
  assign accept       = tick_i.valid && tick_i.ready;

  rlw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_div_q),
    .dividend_i (wheel_rate_q),
    .divisor_i  (speed_q),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  rlw_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_scale_q),
    .bright_i (bright_q),
    .period_i (pwm_period_q),
    .widths_o (widths),
    .stat_o   (scale_stat)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= rlw_pkg::DEB_RESET;
      long_ticks_q <= rlw_pkg::LONG_RESET;
      wheel_rate_q <= rlw_pkg::RATE_RESET;
      pwm_period_q <= rlw_pkg::PWM_RESET;
    end else if (cfg_we_i) begin
      unique case (rlw_pkg::cfg_idx_e'(cfg_idx_i))
        rlw_pkg::CFG_DEBOUNCE: deb_ticks_q  <= cfg_wdata_i[rlw_pkg::DEB_W-1:0];
        rlw_pkg::CFG_LONG:     long_ticks_q <= cfg_wdata_i[rlw_pkg::LONG_W-1:0];
        rlw_pkg::CFG_WHEEL:    wheel_rate_q <= cfg_wdata_i[rlw_pkg::WHEEL_W-1:0];
        rlw_pkg::CFG_PWM:      pwm_period_q <= cfg_wdata_i[rlw_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rlw_pkg::deb_res_t            d1;
    rlw_pkg::deb_res_t            d2;
    logic [TIMER_BITS-1:0]        lc;
    logic [rlw_pkg::DEB_W-1:0]    dc;
    logic [rlw_pkg::WHEEL_W-1:0]  wc;
    logic [rlw_pkg::WHEEL_W-1:0]  wp_eff;
    logic [1:0]                   wch;
    logic                         wup;
    rlw_pkg::wheel_phase_e        wnext;
    logic [rlw_pkg::BRIGHT_W-1:0] b;
    logic [rlw_pkg::SPEED_W-1:0]  s;
    logic [1:0]                   mch;

    state_d       = state_q;
    k1_phase_d    = k1_phase_q;
    k2_phase_d    = k2_phase_q;
    k1_held_d     = k1_held_q;
    k2_held_d     = k2_held_q;
    pending_d     = pending_q;
    deb_count_d   = deb_count_q;
    long_count_d  = long_count_q;
    long_run_d    = long_run_q;
    long_flag_d   = long_flag_q;
    press_d       = press_q;
    wheel_count_d = wheel_count_q;
    wheel_per_d   = wheel_per_q;
    speed_d       = speed_q;
    bright_d      = bright_q;
    wphase_d      = wphase_q;
    mode_d        = mode_q;
    enable_d      = enable_q;
    k2_lvl_d      = k2_lvl_q;
    start_div_d   = 1'b0;
    start_scale_d = 1'b0;
    out_load      = 1'b0;
    out_valid_d   = out_valid_q && !res_o.ready;

    d1     = '0;
    d2     = '0;
    lc     = '0;
    dc     = '0;
    wc     = '0;
    wp_eff = '0;
    wch    = rlw_pkg::CH_R;
    wup    = 1'b0;
    wnext  = rlw_pkg::WP_R_UP;
    b      = '0;
    s      = '0;
    mch    = rlw_pkg::CH_R;

    // A finished wheel period reload lands whenever the divider ends.
    if (div_stat.done) begin
      wheel_per_d = (quot == '0) ? rlw_pkg::WHEEL_W'(1) : quot;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          k2_lvl_d = tick_i.key2_level;
          state_d  = S_WAIT;

          // Long-press one-shot timer.
          if (long_run_q) begin
            lc           = long_count_q + 1'b1;
            long_count_d = lc;
            if (lc >= long_ticks_q[TIMER_BITS-1:0]) begin
              long_flag_d = 1'b1;
              long_run_d  = 1'b0;
            end
          end

          // Debounce divider, key1 machine first.
          dc = deb_count_q + 1'b1;
          deb_count_d = dc;
          if (dc >= deb_ticks_q) begin
            deb_count_d = '0;
            d1 = rlw_pkg::deb_step(k1_phase_q, k1_held_q, tick_i.key1_level);
            d2 = rlw_pkg::deb_step(k2_phase_q, k2_held_q, tick_i.key2_level);
            k1_phase_d = d1.phase;
            k1_held_d  = d1.held;
            k2_phase_d = d2.phase;
            k2_held_d  = d2.held;
            if (d1.press && long_flag_d && (press_q != rlw_pkg::PRESS_SAT)) begin
              press_d = press_q + 1'b1;
            end
            if (d2.press) begin
              long_count_d = '0;
              long_run_d   = 1'b1;
            end else if (!d2.held) begin
              long_run_d = 1'b0;
            end
            pending_d = 1'b1;
          end

          // Wheel timer; the step is dropped while a long press is up.
          wc = wheel_count_q + 1'b1;
          wheel_count_d = wc;
          wp_eff = (wheel_per_q == '0) ? rlw_pkg::WHEEL_W'(1) : wheel_per_q;
          if (wc >= wp_eff) begin
            wheel_count_d = '0;
            start_div_d   = 1'b1;
            if (!long_flag_d) begin
              start_scale_d = 1'b1;
              unique case (mode_q)
                rlw_pkg::MODE_AUTO: begin
                  unique case (wphase_q)
                    rlw_pkg::WP_R_UP: begin
                      wch = rlw_pkg::CH_R; wup = 1'b1; wnext = rlw_pkg::WP_G_DN;
                    end
                    rlw_pkg::WP_G_DN: begin
                      wch = rlw_pkg::CH_G; wup = 1'b0; wnext = rlw_pkg::WP_B_UP;
                    end
                    rlw_pkg::WP_B_UP: begin
                      wch = rlw_pkg::CH_B; wup = 1'b1; wnext = rlw_pkg::WP_R_DN;
                    end
                    rlw_pkg::WP_R_DN: begin
                      wch = rlw_pkg::CH_R; wup = 1'b0; wnext = rlw_pkg::WP_G_UP;
                    end
                    rlw_pkg::WP_G_UP: begin
                      wch = rlw_pkg::CH_G; wup = 1'b1; wnext = rlw_pkg::WP_B_DN;
                    end
                    default: begin
                      wch = rlw_pkg::CH_B; wup = 1'b0; wnext = rlw_pkg::WP_R_UP;
                    end
                  endcase
                  b = wup ? bright_q[wch] + 1'b1 : bright_q[wch] - 1'b1;
                  bright_d[wch] = b;
                  if (wup ? (b >= rlw_pkg::BRIGHT_TOP) : (b <= rlw_pkg::WHEEL_LOW)) begin
                    wphase_d = wnext;
                  end
                end
                rlw_pkg::MODE_RED:   enable_d = 3'b001;
                rlw_pkg::MODE_BLUE:  enable_d = 3'b100;
                rlw_pkg::MODE_GREEN: enable_d = 3'b010;
                default: ;
              endcase
            end
          end
        end
      end

      S_WAIT: begin
        if (!start_div_q && !start_scale_q && !div_stat.busy && !scale_stat.busy) begin
          state_d = S_KEY;
        end
      end

      S_KEY: begin
        state_d = S_OUT;
        if (!long_flag_q && pending_q) begin
          pending_d = 1'b0;
          if (mode_q == rlw_pkg::MODE_AUTO) begin
            s = speed_q;
            if (k1_held_q) begin
              s = s - 1'b1;
              if (s < rlw_pkg::SPEED_MIN) s = rlw_pkg::SPEED_MIN;
            end
            if (k2_held_q) begin
              s = s + 1'b1;
              if (s > rlw_pkg::SPEED_MAX) s = rlw_pkg::SPEED_MAX;
            end
            speed_d = s;
          end else begin
            unique case (mode_q)
              rlw_pkg::MODE_RED:  mch = rlw_pkg::CH_R;
              rlw_pkg::MODE_BLUE: mch = rlw_pkg::CH_B;
              default:            mch = rlw_pkg::CH_G;
            endcase
            b = bright_q[mch];
            if (k1_held_q) begin
              b = b + 1'b1;
              if (b >= rlw_pkg::BRIGHT_TOP) b = rlw_pkg::BRIGHT_TOP;
            end
            if (k2_held_q) begin
              b = b - 1'b1;
              if (b <= rlw_pkg::BRIGHT_LOW) b = rlw_pkg::BRIGHT_LOW;
            end
            bright_d[mch] = b;
          end
        end
        // Long press: blank, then pick the manual color on key2 release.
        if (long_flag_q) begin
          enable_d = 3'b000;
          if (k2_lvl_q) begin
            if (press_q >= 8'd1 && press_q <= 8'd3) begin
              mode_d = rlw_pkg::mode_e'(press_q[1:0]);
            end
            press_d     = '0;
            long_flag_d = 1'b0;
            enable_d    = 3'b111;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      k1_phase_q    <= rlw_pkg::PH_IDLE;
      k2_phase_q    <= rlw_pkg::PH_IDLE;
      k1_held_q     <= 1'b0;
      k2_held_q     <= 1'b0;
      pending_q     <= 1'b0;
      deb_count_q   <= '0;
      long_count_q  <= '0;
      long_run_q    <= 1'b0;
      long_flag_q   <= 1'b0;
      press_q       <= '0;
      wheel_count_q <= '0;
      wheel_per_q   <= rlw_pkg::WPER_RESET;
      speed_q       <= rlw_pkg::SPEED_RESET;
      bright_q      <= {3{rlw_pkg::BRIGHT_LOW}};
      wphase_q      <= rlw_pkg::WP_R_UP;
      mode_q        <= rlw_pkg::MODE_AUTO;
      enable_q      <= 3'b111;
      k2_lvl_q      <= 1'b1;
      start_div_q   <= 1'b0;
      start_scale_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      k1_phase_q    <= k1_phase_d;
      k2_phase_q    <= k2_phase_d;
      k1_held_q     <= k1_held_d;
      k2_held_q     <= k2_held_d;
      pending_q     <= pending_d;
      deb_count_q   <= deb_count_d;
      long_count_q  <= long_count_d;
      long_run_q    <= long_run_d;
      long_flag_q   <= long_flag_d;
      press_q       <= press_d;
      wheel_count_q <= wheel_count_d;
      wheel_per_q   <= wheel_per_d;
      speed_q       <= speed_d;
      bright_q      <= bright_d;
      wphase_q      <= wphase_d;
      mode_q        <= mode_d;
      enable_q      <= enable_d;
      k2_lvl_q      <= k2_lvl_d;
      start_div_q   <= start_div_d;
      start_scale_q <= start_scale_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_o.red_width         <= widths[rlw_pkg::CH_R];
      res_o.green_width       <= widths[rlw_pkg::CH_G];
      res_o.blue_width        <= widths[rlw_pkg::CH_B];
      res_o.red_enable        <= enable_q[0];
      res_o.green_enable      <= enable_q[1];
      res_o.blue_enable       <= enable_q[2];
      res_o.mode              <= mode_q;
      res_o.long_press_active <= long_flag_q;
      res_o.speed             <= speed_q;
    end
  end

  assign res_o.valid = out_valid_q;

  `RLW_ASSERT(a_speed_range, (speed_q >= rlw_pkg::SPEED_MIN) && (speed_q <= rlw_pkg::SPEED_MAX), "speed left its clamp range")
  `RLW_ASSERT(a_period_nonzero, wheel_per_q != '0, "wheel period reloaded as zero")
  `RLW_ASSERT(a_accept_busy, accept |=> (state_q == S_WAIT), "tick accepted but sequencer did not start")
  `RLW_ASSERT(a_div_done_wait, div_stat.done |-> (state_q == S_WAIT), "divider finished outside the wait state")

endmodule
